>>> rtl/dsu_pkg.sv
`default_nettype none

package dsu_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = 7;
    localparam int RANK_W       = 3;

    localparam logic [RANK_W-1:0] RANK_INIT   = RANK_W'(1);
    localparam logic [RANK_W-1:0] RANK_MAX    = RANK_W'(7);
    localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0]  COUNT_MIN   = CNT_W'(1);

    localparam logic MODE_MERGE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] elem_a;
        logic [IDX_W-1:0] elem_b;
    } dsu_item_t;

    typedef struct packed {
        logic same_set;
        logic range_error;
    } dsu_result_t;

    // Requests from the sequencer to the forest storage.
    typedef struct packed {
        logic [IDX_W-1:0]  par_rd_addr;
        logic              par_we;
        logic [IDX_W-1:0]  par_wr_addr;
        logic [IDX_W-1:0]  par_wr_data;
        logic [IDX_W-1:0]  rank_rd_addr;
        logic              rank_we;
        logic [IDX_W-1:0]  rank_wr_addr;
        logic [RANK_W-1:0] rank_wr_data;
    } dsu_mem_req_t;

    // Read data, valid in the cycle after the address.
    typedef struct packed {
        logic [IDX_W-1:0]  parent;
        logic [RANK_W-1:0] rank;
    } dsu_mem_rsp_t;

endpackage

`default_nettype wire

>>> rtl/disjoint_set_union_find.sv
// Disjoint-set forest with union by rank and path compression over up to 64
// elements. Pulse start with an item while busy is low; the item is taken at
// that edge. Its single result beat appears on result for exactly one cycle
// with done high, and cannot be held off, so sample it whenever done is set.
// An item with an index not below element_count returns range_error in the
// cycle after it is taken and leaves the forest alone. Otherwise each of the
// two finds walks up its path to the root and then makes a compression pass
// back along it, through a single read port of the parent memory; a valid
// item holds busy high through both finds, plus a rank read of each root
// when two different sets are merged, and its result beat comes in the same
// cycle that busy falls.
// Writing element_count (clamped to 1..64) reinitializes the whole forest at
// once; write it only while the block is idle. No clearing pass is needed.
`default_nettype none

module disjoint_set_union_find
    import dsu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_wdata,
    input  wire logic             start,
    input  wire dsu_item_t        item,
    output logic                  busy,
    output logic                  done,
    output dsu_result_t           result
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    dsu_mem_req_t     req;
    dsu_mem_rsp_t     rsp;

    // Clamp the written count into the supported range.
    always_comb begin
        count_next = count_reg;
        if (cfg_we) begin
            if (cfg_wdata == '0) begin
                count_next = COUNT_MIN;
            end else if (cfg_wdata > COUNT_RESET) begin
                count_next = COUNT_RESET;
            end else begin
                count_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= COUNT_RESET;
        end else begin
            count_reg <= count_next;
        end
    end

    dsu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .count  (count_reg),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result),
        .req    (req),
        .rsp    (rsp)
    );

    // A configuration write drops every stored entry back to its reset value.
    dsu_forest u_forest (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_we),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

>>> rtl/dsu_forest.sv
`default_nettype none

module dsu_forest
    import dsu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         clear,
    input  wire dsu_mem_req_t req,
    output dsu_mem_rsp_t      rsp
);

    logic [IDX_W-1:0]        par_mem  [MAX_ELEMENTS];
    logic [RANK_W-1:0]       rank_mem [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] par_vld_reg;
    logic [MAX_ELEMENTS-1:0] rank_vld_reg;

    logic [IDX_W-1:0]  par_data_reg;
    logic [IDX_W-1:0]  par_addr_reg;
    logic              par_hit_reg;
    logic [RANK_W-1:0] rank_data_reg;
    logic              rank_hit_reg;

    always_ff @(posedge clk) begin
        if (req.par_we) begin
            par_mem[req.par_wr_addr] <= req.par_wr_data;
        end
        if (req.rank_we) begin
            rank_mem[req.rank_wr_addr] <= req.rank_wr_data;
        end
        par_data_reg  <= par_mem[req.par_rd_addr];
        par_addr_reg  <= req.par_rd_addr;
        rank_data_reg <= rank_mem[req.rank_rd_addr];
    end

    // An entry never written since the last clear reads as its reset value.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            par_vld_reg  <= '0;
            rank_vld_reg <= '0;
            par_hit_reg  <= 1'b0;
            rank_hit_reg <= 1'b0;
        end else begin
            par_hit_reg  <= par_vld_reg[req.par_rd_addr];
            rank_hit_reg <= rank_vld_reg[req.rank_rd_addr];
            if (clear) begin
                par_vld_reg  <= '0;
                rank_vld_reg <= '0;
            end else begin
                if (req.par_we) begin
                    par_vld_reg[req.par_wr_addr] <= 1'b1;
                end
                if (req.rank_we) begin
                    rank_vld_reg[req.rank_wr_addr] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        rsp.parent = par_hit_reg ? par_data_reg : par_addr_reg;
        rsp.rank   = rank_hit_reg ? rank_data_reg : RANK_INIT;
    end

endmodule

`default_nettype wire

>>> rtl/dsu_ctrl.sv
`default_nettype none

module dsu_ctrl
    import dsu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             start,
    input  wire dsu_item_t        item,
    output logic                  busy,
    output logic                  done,
    output dsu_result_t           result,
    output dsu_mem_req_t          req,
    input  wire dsu_mem_rsp_t     rsp
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WALK   = 5'b00010,
        ST_COMP   = 5'b00100,
        ST_RANK_A = 5'b01000,
        ST_RANK_B = 5'b10000
    } state_t;

    state_t            state_reg,  state_next;
    logic              mode_reg,   mode_next;
    logic [IDX_W-1:0]  elem_b_reg, elem_b_next;
    logic [IDX_W-1:0]  cur_reg,    cur_next;
    logic [IDX_W-1:0]  origin_reg, origin_next;
    logic [IDX_W-1:0]  root_reg,   root_next;
    logic [IDX_W-1:0]  root_a_reg, root_a_next;
    logic              second_reg, second_next;
    logic [RANK_W-1:0] rank_a_reg, rank_a_next;
    logic              done_reg,   done_next;
    dsu_result_t       res_reg,    res_next;

    logic range_bad;
    logic link_is_root;
    logic at_root;
    logic roots_equal;

    assign range_bad = ({1'b0, item.elem_a} >= count) || ({1'b0, item.elem_b} >= count);

    // The equality compare of the walk, plus the root checks.
    assign link_is_root = (rsp.parent == cur_reg);
    assign at_root      = (cur_reg == root_reg);
    assign roots_equal  = (root_a_reg == root_reg);

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        elem_b_next = elem_b_reg;
        cur_next    = cur_reg;
        origin_next = origin_reg;
        root_next   = root_reg;
        root_a_next = root_a_reg;
        second_next = second_reg;
        rank_a_next = rank_a_reg;
        done_next   = 1'b0;
        res_next    = res_reg;

        req              = '0;
        req.par_rd_addr  = cur_reg;
        req.rank_rd_addr = root_a_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (range_bad) begin
                        done_next            = 1'b1;
                        res_next.same_set    = 1'b0;
                        res_next.range_error = 1'b1;
                    end else begin
                        mode_next       = item.mode;
                        elem_b_next     = item.elem_b;
                        cur_next        = item.elem_a;
                        origin_next     = item.elem_a;
                        second_next     = 1'b0;
                        req.par_rd_addr = item.elem_a;
                        state_next      = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (link_is_root) begin
                    root_next       = cur_reg;
                    cur_next        = origin_reg;
                    req.par_rd_addr = origin_reg;
                    state_next      = ST_COMP;
                end else begin
                    cur_next        = rsp.parent;
                    req.par_rd_addr = rsp.parent;
                end
            end
            ST_COMP: begin
                if (at_root) begin
                    if (!second_reg) begin
                        root_a_next     = root_reg;
                        second_next     = 1'b1;
                        cur_next        = elem_b_reg;
                        origin_next     = elem_b_reg;
                        req.par_rd_addr = elem_b_reg;
                        state_next      = ST_WALK;
                    end else if (mode_reg == MODE_QUERY || roots_equal) begin
                        done_next            = 1'b1;
                        res_next.same_set    = roots_equal;
                        res_next.range_error = 1'b0;
                        state_next           = ST_IDLE;
                    end else begin
                        req.rank_rd_addr = root_a_reg;
                        state_next       = ST_RANK_A;
                    end
                end else begin
                    // Point this node straight at the root and move on.
                    req.par_we      = 1'b1;
                    req.par_wr_addr = cur_reg;
                    req.par_wr_data = root_reg;
                    cur_next        = rsp.parent;
                    req.par_rd_addr = rsp.parent;
                end
            end
            ST_RANK_A: begin
                rank_a_next      = rsp.rank;
                req.rank_rd_addr = root_reg;
                state_next       = ST_RANK_B;
            end
            ST_RANK_B: begin
                if (rank_a_reg < rsp.rank) begin
                    req.par_we      = 1'b1;
                    req.par_wr_addr = root_a_reg;
                    req.par_wr_data = root_reg;
                end else begin
                    req.par_we      = 1'b1;
                    req.par_wr_addr = root_reg;
                    req.par_wr_data = root_a_reg;
                    if (rank_a_reg == rsp.rank && rank_a_reg != RANK_MAX) begin
                        req.rank_we      = 1'b1;
                        req.rank_wr_addr = root_a_reg;
                        req.rank_wr_data = RANK_W'(rank_a_reg + 1'b1);
                    end
                end
                done_next            = 1'b1;
                res_next.same_set    = 1'b0;
                res_next.range_error = 1'b0;
                state_next           = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        mode_reg   <= mode_next;
        elem_b_reg <= elem_b_next;
        cur_reg    <= cur_next;
        origin_reg <= origin_next;
        root_reg   <= root_next;
        root_a_reg <= root_a_next;
        second_reg <= second_next;
        rank_a_reg <= rank_a_next;
        res_reg    <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

>>> verif/tb_disjoint_set_union_find.sv
`timescale 1ns / 1ps

module tb_disjoint_set_union_find;
    import dsu_pkg::*;

    // Quiet cycles (nothing taken, no result, no register write) before the run is
    // declared hung. The limit is many times the slowest item, the longest sender
    // gap and the settle wait before a register write taken together.
    localparam int QUIET_LIMIT  = 2000;
    // Idle cycles required before a register write once every result is back.
    localparam int CFG_SETTLE   = 4;
    // Cycles kept after the last result to catch stray result beats.
    localparam int DRAIN_CYCLES = 40;
    // Items to queue, directed part included, before the closing full-size phase.
    localparam int RANDOM_ITEMS = 900;
    // The final items are sent back to back with no sender gaps.
    localparam int TAIL_ITEMS   = 150;

    // One queued operation: either an input beat or a write of element_count.
    typedef struct {
        bit               is_cfg;
        logic [CNT_W-1:0] cfg_val;
        dsu_item_t        beat;
    } stim_op_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             start     = 1'b0;
    dsu_item_t        item      = '0;
    logic             busy;
    logic             done;
    dsu_result_t      result;

    disjoint_set_union_find u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    // ------------------------------------------------------------------
    // Predicted forest. It is a copy of the block's parent links, ranks and
    // element count. It is updated at the same edges at which the block
    // takes a beat or a register write.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  forest_parent [MAX_ELEMENTS];
    logic [RANK_W-1:0] forest_rank   [MAX_ELEMENTS];
    int                forest_count;

    stim_op_t    pending_ops[$];
    dsu_result_t expected_results[$];

    int n_queued;
    int n_accepted;
    int n_cfg_writes;
    int n_results;
    int n_range_errors;
    int n_same_hits;
    int n_fail;
    int tail_start;

    // Driver-private bookkeeping.
    int gap_left;
    int settle;
    bit idle_on;

    // A write of element_count clamps the value to 1..MAX_ELEMENTS.
    // Every write rebuilds the forest, even when the value does not change.
    function automatic void forest_init(input logic [CNT_W-1:0] value);
        if (value == 0)
            forest_count = COUNT_MIN;
        else if (value > MAX_ELEMENTS)
            forest_count = MAX_ELEMENTS;
        else
            forest_count = value;
        for (int k = 0; k < MAX_ELEMENTS; k++)
        begin
            forest_parent[k] = IDX_W'(k);
            forest_rank[k]   = RANK_INIT;
        end
    endfunction

    // Walks up to the root. A second walk then points every node on the
    // path straight at that root (path compression).
    function automatic logic [IDX_W-1:0] root_of(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] root;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        int               steps;
        root  = x;
        steps = 0;
        while (forest_parent[root] != root && steps < MAX_ELEMENTS)
        begin
            root = forest_parent[root];
            steps++;
        end
        cur   = x;
        steps = 0;
        while (cur != root && steps < MAX_ELEMENTS)
        begin
            nxt                = forest_parent[cur];
            forest_parent[cur] = root;
            cur                = nxt;
            steps++;
        end
        return root;
    endfunction

    // Works out the result of one beat and applies its effect on the forest.
    // Queries compress paths too. A merge hangs the root of lower rank under
    // the other root. On equal ranks the root of elem_a wins and gains a rank,
    // and the rank saturates at RANK_MAX.
    function automatic dsu_result_t predict_result(input dsu_item_t beat);
        dsu_result_t      r;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        r = '0;
        if (beat.elem_a >= forest_count || beat.elem_b >= forest_count)
        begin
            r.range_error = 1'b1;
            return r;
        end
        ra         = root_of(beat.elem_a);
        rb         = root_of(beat.elem_b);
        r.same_set = (ra == rb);
        if (beat.mode == MODE_MERGE && ra != rb)
        begin
            if (forest_rank[ra] < forest_rank[rb])
                forest_parent[ra] = rb;
            else
            begin
                forest_parent[rb] = ra;
                if (forest_rank[ra] == forest_rank[rb] && forest_rank[ra] < RANK_MAX)
                    forest_rank[ra] = forest_rank[ra] + 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders. They only append to the queue of pending work.
    // ------------------------------------------------------------------
    task automatic add_item(input logic mode, input int a, input int b);
        stim_op_t op;
        op.is_cfg      = 1'b0;
        op.cfg_val     = '0;
        op.beat.mode   = mode;
        op.beat.elem_a = IDX_W'(a);
        op.beat.elem_b = IDX_W'(b);
        pending_ops    = {pending_ops, op};
        n_queued++;
    endtask

    task automatic add_count(input logic [CNT_W-1:0] value);
        stim_op_t op;
        op.is_cfg   = 1'b1;
        op.cfg_val  = value;
        op.beat     = '0;
        pending_ops = {pending_ops, op};
    endtask

    // Merges a shuffled set of the live elements in the pattern of a
    // binomial tree: pairs, then pairs of pairs, and so on. At a power-of-two
    // count every merge joins two roots of equal rank. At full size the final
    // root gets the top rank; find paths are as long as union by rank allows.
    task automatic add_balanced_build(input int c);
        int perm [MAX_ELEMENTS];
        int j;
        int tmp;
        for (int k = 0; k < c; k++)
            perm[k] = k;
        for (int k = c - 1; k > 0; k--)
        begin
            j       = $urandom_range(0, k);
            tmp     = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        for (int s = 1; s < c; s = s * 2)
            for (int k = 0; k + s < c; k += 2 * s)
                add_item(MODE_MERGE, perm[k], perm[k + s]);
    endtask

    // Mostly well-formed beats on live elements. The rest is noise over the
    // whole 6-bit index range, so range errors and every index bit show up.
    task automatic add_random_phase(input int c, input int n);
        int   merge_pct;
        int   a;
        int   b;
        logic mode;
        merge_pct = $urandom_range(15, 85);
        for (int k = 0; k < n; k++)
        begin
            mode = ($urandom_range(0, 99) < merge_pct) ? MODE_MERGE : MODE_QUERY;
            if ($urandom_range(0, 6) == 0)
            begin
                a = $urandom_range(0, MAX_ELEMENTS - 1);
                b = $urandom_range(0, MAX_ELEMENTS - 1);
            end
            else
            begin
                a = $urandom_range(0, c - 1);
                b = ($urandom_range(0, 15) == 0) ? a : $urandom_range(0, c - 1);
            end
            add_item(mode, a, b);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock: a 10 ns period.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver. At each rising edge it first records what the block took at
    // that edge: a register write, or a beat when start is high and busy is
    // low. The prediction is made at that point. The driver then decides what
    // to drive next. A register write waits until every result is back and the
    // block has stayed idle through the CFG_SETTLE wait. Each input gets
    // exactly one nonblocking assignment per edge, so a start that stays high
    // for the next beat is never dropped and raised in the same step.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit               took;
        logic             start_n;
        logic             cfg_we_n;
        logic [CNT_W-1:0] cfg_wdata_n;
        dsu_item_t        item_n;
        dsu_result_t      pred;
        if (!rst_n)
        begin
            start     <= 1'b0;
            item      <= '0;
            cfg_we    <= 1'b0;
            cfg_wdata <= '0;
            gap_left   = 0;
            settle     = 0;
            idle_on    = 1'b1;
        end
        else
        begin
            took = start && !busy;
            if (cfg_we)
            begin
                forest_init(cfg_wdata);
                n_cfg_writes++;
            end
            if (took)
            begin
                pred             = predict_result(item);
                expected_results = {expected_results, pred};
                void'(pending_ops.pop_front());
                n_accepted++;
                // Gaps come in bursts. Some stretches have none, and the
                // final part of the run has none either.
                if (n_accepted % 50 == 0)
                    idle_on = 1'($urandom_range(0, 1));
                if (idle_on && n_accepted < tail_start && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 15);
            end

            start_n     = 1'b0;
            cfg_we_n    = 1'b0;
            cfg_wdata_n = cfg_wdata;
            item_n      = item;
            if (gap_left > 0)
                gap_left--;
            else if (pending_ops.size() > 0)
            begin
                if (pending_ops[0].is_cfg)
                begin
                    if (!cfg_we && !took && !busy && expected_results.size() == 0)
                        settle++;
                    else
                        settle = 0;
                    if (settle >= CFG_SETTLE)
                    begin
                        cfg_we_n    = 1'b1;
                        cfg_wdata_n = pending_ops[0].cfg_val;
                        void'(pending_ops.pop_front());
                        settle = 0;
                    end
                end
                else
                begin
                    start_n = 1'b1;
                    item_n  = pending_ops[0].beat;
                end
            end
            start     <= start_n;
            item      <= item_n;
            cfg_we    <= cfg_we_n;
            cfg_wdata <= cfg_wdata_n;
        end
    end

    // ------------------------------------------------------------------
    // Monitor. A result beat lasts one cycle and cannot be held off. It is
    // checked field by field against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dsu_result_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: same_set=%0b range_error=%0b",
                       result.same_set, result.range_error);
                n_fail++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.range_error)
                    n_range_errors++;
                if (want.same_set)
                    n_same_hits++;
                if (result.same_set !== want.same_set)
                begin
                    $error("same_set mismatch: expected %0b, actual %0b",
                           want.same_set, result.same_set);
                    n_fail++;
                end
                if (result.range_error !== want.range_error)
                begin
                    $error("range_error mismatch: expected %0b, actual %0b",
                           want.range_error, result.range_error);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog. It counts cycles in which nothing moves. An expectation
    // that never arrives ends the run here as a failure.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, expected_results.size());
                $display("disjoint_set_union_find test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence. It fills the queue of pending work, applies reset once,
    // and then waits for the run to drain.
    // ------------------------------------------------------------------
    initial
    begin
        int v;
        int c;
        rst_n = 1'b0;
        forest_init(COUNT_RESET);

        // Directed part. It starts from the reset forest, with no register write.
        add_item(MODE_QUERY, 0, 0);       // an element is in its own set
        add_item(MODE_QUERY, 63, 0);      // highest index, separate sets
        add_item(MODE_MERGE, 0, 63);
        add_item(MODE_MERGE, 63, 0);      // merge of elements already together
        add_item(MODE_MERGE, 1, 2);
        add_item(MODE_MERGE, 3, 4);
        add_item(MODE_MERGE, 1, 3);       // equal ranks: the root of elem_a gains a rank
        add_item(MODE_MERGE, 5, 6);
        add_item(MODE_MERGE, 7, 8);
        add_item(MODE_MERGE, 5, 7);
        add_item(MODE_MERGE, 1, 5);       // builds a chain three links deep
        add_item(MODE_QUERY, 8, 4);       // a query that compresses a long path
        add_item(MODE_MERGE, 9, 1);       // the lower-rank root of elem_a goes under
        add_item(MODE_MERGE, 1, 10);      // the lower-rank root of elem_b goes under
        add_item(MODE_QUERY, 10, 9);
        add_item(MODE_MERGE, 0, 1);
        add_item(MODE_QUERY, 63, 8);
        add_count(CNT_W'(0));             // a zero count is clamped to one element
        add_item(MODE_QUERY, 0, 0);
        add_item(MODE_MERGE, 0, 1);       // elem_b out of range
        add_item(MODE_MERGE, 1, 0);       // elem_a out of range
        add_item(MODE_QUERY, 63, 63);
        add_count(CNT_W'(127));           // an oversized count is clamped to the maximum
        add_item(MODE_QUERY, 62, 63);
        add_item(MODE_MERGE, 63, 62);
        add_item(MODE_QUERY, 62, 63);
        add_count(COUNT_RESET);           // a rewrite of the same value still clears
        add_item(MODE_QUERY, 62, 63);

        // Random part, in phases. Each phase starts with a register write.
        while (n_queued < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: v = 0;
                1: v = 1;
                2: v = 2;
                3: v = MAX_ELEMENTS;
                4: v = 127;
                default: v = $urandom_range(0, 127);
            endcase
            c = (v == 0) ? 1 : ((v > MAX_ELEMENTS) ? MAX_ELEMENTS : v);
            add_count(CNT_W'(v));
            if ($urandom_range(0, 2) == 0)
                add_balanced_build(c);
            add_random_phase(c, $urandom_range(40, 110));
        end
        // The full-size forest is built to the top rank. It is then queried
        // and merged back to back.
        add_count(COUNT_RESET);
        add_balanced_build(MAX_ELEMENTS);
        add_random_phase(MAX_ELEMENTS, 60);
        tail_start = n_queued - TAIL_ITEMS;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats and %0d results under %0d element_count writes",
                 n_accepted, n_results, n_cfg_writes);
        $display("results included %0d range errors and %0d already in one set",
                 n_range_errors, n_same_hits);
        if (n_fail == 0)
            $display("disjoint_set_union_find test passed");
        else
            $display("disjoint_set_union_find test failed");
        $finish;
    end

endmodule

>>> disjoint_set_union_find.f
rtl/dsu_pkg.sv
rtl/dsu_forest.sv
rtl/dsu_ctrl.sv
rtl/disjoint_set_union_find.sv
verif/tb_disjoint_set_union_find.sv
